FILE: hdl/bmm_pkg.sv
// bmm_pkg: shared types and address constants for the banked memory map
// used by banked_memory_map_soft_switches_unit and the testbench
// no dependencies
package bmm_pkg;

  localparam int unsigned MainDepthDef = 65536;
  localparam int unsigned BankDepthDef = 4096;

  localparam logic [7:0]  IoPageHi    = 8'hC0;
  localparam logic [15:0] SpeakerAddr = 16'hC030;
  localparam logic [11:0] CardPageHi  = 12'hC08;
  localparam logic [3:0]  WindowHi    = 4'hD;
  localparam logic [15:0] WindowLow   = 16'hD000;

  localparam int unsigned BankBit = 3;

  localparam logic [1:0] ModeRamRo   = 2'd0;
  localparam logic [1:0] ModeMainRw  = 2'd1;
  localparam logic [1:0] ModeMainRo  = 2'd2;
  localparam logic [1:0] ModeRamRw   = 2'd3;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef enum logic [1:0] {
    SrcNone,
    SrcMain,
    SrcBank
  } src_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       speaker_toggle;
  } rsp_t;

endpackage

FILE: hdl/banked_memory_map_soft_switches_unit.sv
// banked_memory_map_soft_switches_unit: 64K main store, two 4K window banks
// and language-card switches; depends on bmm_pkg and bmm_ram
//
//   channel   ports                 flow control
//   access    start, req_i          taken when start high and busy low
//   result    done_o, rsp_o         one-cycle strobe, no back pressure
//
// one access per cycle while busy is low; each result appears the cycle after
// its access, since the stores register their read data
// after reset busy stays high while a sweep zeroes main store and both banks,
// one entry a cycle
// busy is low from then on; results are never stalled
module banked_memory_map_soft_switches_unit #(
  parameter int unsigned MAIN_DEPTH = bmm_pkg::MainDepthDef,
  parameter int unsigned BANK_DEPTH = bmm_pkg::BankDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bmm_pkg::req_t req_i,
  output logic          done_o,
  output bmm_pkg::rsp_t rsp_o
);

  localparam int unsigned MainAw = $clog2(MAIN_DEPTH);
  localparam int unsigned BankAw = $clog2(BANK_DEPTH);
  localparam int unsigned BankMemAw = BankAw + 1;

  logic              clearing_q, clearing_d;
  logic [MainAw-1:0] clr_cnt_q, clr_cnt_d;
  logic              rram_q, rram_d;
  logic              wen_q, wen_d;
  logic              bank1_q, bank1_d;
  logic              done_q;
  logic              spk_q;
  bmm_pkg::src_e     src_q, src_d;

  logic              accept;
  logic [15:0]       addr;
  logic              is_io, is_spk, is_card, is_window, is_upper, is_wr;
  logic [15:0]       win_off;
  logic              main_en, main_we, bank_en, bank_we;
  logic [MainAw-1:0] main_addr;
  logic [BankMemAw-1:0] bank_addr;
  logic [7:0]        main_wdata, bank_wdata, main_rdata, bank_rdata;

  assign accept    = start && !busy;
  assign addr      = req_i.bus_address;
  assign is_wr     = req_i.opcode == bmm_pkg::OpWrite;
  assign is_io     = addr[15:8] == bmm_pkg::IoPageHi;
  assign is_spk    = addr == bmm_pkg::SpeakerAddr;
  assign is_card   = addr[15:4] == bmm_pkg::CardPageHi;
  assign is_window = addr[15:12] == bmm_pkg::WindowHi;
  assign is_upper  = addr >= bmm_pkg::WindowLow;
  assign win_off   = addr - bmm_pkg::WindowLow;

  always_comb begin
    main_en    = 1'b0;
    main_we    = 1'b0;
    bank_en    = 1'b0;
    bank_we    = 1'b0;
    main_addr  = addr[MainAw-1:0];
    bank_addr  = {bank1_q, win_off[BankAw-1:0]};
    main_wdata = req_i.write_data;
    bank_wdata = req_i.write_data;
    src_d      = bmm_pkg::SrcNone;
    rram_d     = rram_q;
    wen_d      = wen_q;
    bank1_d    = bank1_q;
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      main_en    = 1'b1;
      main_we    = 1'b1;
      bank_en    = 1'b1;
      bank_we    = 1'b1;
      main_addr  = clr_cnt_q;
      bank_addr  = clr_cnt_q[BankMemAw-1:0];
      main_wdata = '0;
      bank_wdata = '0;
      clr_cnt_d  = clr_cnt_q + MainAw'(1);
      if (clr_cnt_q == MainAw'(MAIN_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (accept) begin
      if (is_io) begin
        if (is_card && !is_spk) begin
          bank1_d = addr[bmm_pkg::BankBit];
          rram_d  = (addr[1:0] == bmm_pkg::ModeRamRo) || (addr[1:0] == bmm_pkg::ModeRamRw);
          wen_d   = (addr[1:0] == bmm_pkg::ModeMainRw) || (addr[1:0] == bmm_pkg::ModeRamRw);
        end
      end else if (is_wr) begin
        if (!is_upper) begin
          main_en = 1'b1;
          main_we = 1'b1;
        end else if (wen_q) begin
          if (is_window) begin
            bank_en = 1'b1;
            bank_we = 1'b1;
          end else begin
            main_en = 1'b1;
            main_we = 1'b1;
          end
        end
      end else if (is_window && rram_q) begin
        bank_en = 1'b1;
        src_d   = bmm_pkg::SrcBank;
      end else begin
        main_en = 1'b1;
        src_d   = bmm_pkg::SrcMain;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      rram_q     <= 1'b0;
      wen_q      <= 1'b0;
      bank1_q    <= 1'b0;
      done_q     <= 1'b0;
      spk_q      <= 1'b0;
      src_q      <= bmm_pkg::SrcNone;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      rram_q     <= rram_d;
      wen_q      <= wen_d;
      bank1_q    <= bank1_d;
      done_q     <= accept;
      spk_q      <= accept && is_spk;
      src_q      <= src_d;
    end
  end

  bmm_ram #(
    .Depth (MAIN_DEPTH),
    .Width (8)
  ) u_main_ram (
    .clk_i   (clk_i),
    .en_i    (main_en),
    .we_i    (main_we),
    .addr_i  (main_addr),
    .wdata_i (main_wdata),
    .rdata_o (main_rdata)
  );

  // bank one in the upper half, bank two in the lower half
  bmm_ram #(
    .Depth (2 * BANK_DEPTH),
    .Width (8)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .en_i    (bank_en),
    .we_i    (bank_we),
    .addr_i  (bank_addr),
    .wdata_i (bank_wdata),
    .rdata_o (bank_rdata)
  );

  always_comb begin
    rsp_o.speaker_toggle = spk_q;
    case (src_q)
      bmm_pkg::SrcMain: rsp_o.read_data = main_rdata;
      bmm_pkg::SrcBank: rsp_o.read_data = bank_rdata;
      default:          rsp_o.read_data = '0;
    endcase
  end

  assign busy   = clearing_q;
  assign done_o = done_q;

  a_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o)
    else $error("accepted word gave no result");

  a_no_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !done_o)
    else $error("result without an accepted word");

  a_spk_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.speaker_toggle |-> done_o && rsp_o.read_data == 8'd0)
    else $error("speaker word carried data");

  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.opcode == bmm_pkg::OpWrite |=> rsp_o.read_data == 8'd0)
    else $error("write returned data");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("clear sweep restarted");

endmodule

FILE: hdl/bmm_ram.sv
// bmm_ram: single-port synchronous byte store with registered read data
// no dependencies
module bmm_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/testbench.sv
// testbench for banked_memory_map_soft_switches_unit: directed and random bus words
// checked against planned values or a shadow copy of main store, both banks and the card flags
// depends on bmm_pkg and the unit under test
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RandomWords = 1550;

  typedef struct packed {
    bmm_pkg::req_t acc;
    logic          typed;
    bmm_pkg::rsp_t want;
  } plan_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  bmm_pkg::req_t req_bus;
  logic          done;
  bmm_pkg::rsp_t rsp_bus;

  logic [7:0] shadow_main  [bmm_pkg::MainDepthDef];
  logic [7:0] shadow_bank1 [bmm_pkg::BankDepthDef];
  logic [7:0] shadow_bank2 [bmm_pkg::BankDepthDef];
  logic       lc_read_ram;
  logic       lc_write_en;
  logic       lc_bank1;

  bmm_pkg::rsp_t awaited_rsp [$];
  bmm_pkg::rsp_t head_rsp;
  plan_row_t     plan [$];
  int unsigned   fails;
  int unsigned   results_seen;
  int unsigned   n_reads;
  int unsigned   n_writes;
  int unsigned   n_card;
  int unsigned   n_speaker;
  int unsigned   n_window;

  banked_memory_map_soft_switches_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req_bus),
    .done_o (done),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic plan_row_t row(input logic op, input logic [15:0] addr,
                                    input logic [7:0] data, input logic typed,
                                    input logic [7:0] rd, input logic spk);
    plan_row_t r;
    r.acc.opcode              = op;
    r.acc.bus_address         = addr;
    r.acc.write_data          = data;
    r.typed                   = typed;
    r.want.read_data          = rd;
    r.want.speaker_toggle     = spk;
    return r;
  endfunction

  task automatic predict_bus_access(input bmm_pkg::req_t acc, output bmm_pkg::rsp_t res);
    logic [15:0] a;
    logic [11:0] off;
    logic        in_window;
    a         = acc.bus_address;
    off       = a[11:0];
    in_window = (a[15:12] == bmm_pkg::WindowHi);
    res       = '0;
    if (a[15:8] == bmm_pkg::IoPageHi) begin
      if (a == bmm_pkg::SpeakerAddr) begin
        res.speaker_toggle = 1'b1;
        n_speaker++;
      end else if (a[15:4] == bmm_pkg::CardPageHi) begin
        n_card++;
        lc_bank1 = a[bmm_pkg::BankBit];
        case (a[1:0])
          bmm_pkg::ModeRamRo: begin
            lc_read_ram = 1'b1;
            lc_write_en = 1'b0;
          end
          bmm_pkg::ModeMainRw: begin
            lc_read_ram = 1'b0;
            lc_write_en = 1'b1;
          end
          bmm_pkg::ModeMainRo: begin
            lc_read_ram = 1'b0;
            lc_write_en = 1'b0;
          end
          default: begin
            lc_read_ram = 1'b1;
            lc_write_en = 1'b1;
          end
        endcase
      end
    end else if (acc.opcode == bmm_pkg::OpWrite) begin
      n_writes++;
      if (a < bmm_pkg::WindowLow) begin
        shadow_main[a] = acc.write_data;
      end else if (lc_write_en) begin
        if (in_window) begin
          n_window++;
          if (lc_bank1) shadow_bank1[off] = acc.write_data;
          else shadow_bank2[off] = acc.write_data;
        end else begin
          shadow_main[a] = acc.write_data;
        end
      end
    end else begin
      n_reads++;
      if (in_window && lc_read_ram) begin
        n_window++;
        res.read_data = lc_bank1 ? shadow_bank1[off] : shadow_bank2[off];
      end else begin
        res.read_data = shadow_main[a];
      end
    end
  endtask

  function automatic logic [15:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 9) return {bmm_pkg::CardPageHi, 4'($urandom)};
    if (r < 12) return bmm_pkg::SpeakerAddr;
    if (r < 17) return {bmm_pkg::IoPageHi, 8'($urandom)};
    if (r < 47) return {bmm_pkg::WindowHi, ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                        4'($urandom)};
    if (r < 64) return ($urandom_range(0, 1) ? 16'hE000 : 16'hFFF0) | 16'($urandom_range(0, 15));
    if (r < 88) return ($urandom_range(0, 1) ? 16'h0000 : 16'hBFF0) | 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(input bmm_pkg::req_t acc, input logic typed, input bmm_pkg::rsp_t want);
    bmm_pkg::rsp_t model_res;
    start   <= 1'b1;
    req_bus <= acc;
    do @(posedge clk); while (busy);
    predict_bus_access(acc, model_res);
    awaited_rsp.push_back(typed ? want : model_res);
  endtask

  task automatic pause_bus(input int unsigned n);
    if (n != 0) begin
      start   <= 1'b0;
      req_bus <= bmm_pkg::req_t'(25'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && done) begin
      results_seen++;
      if (awaited_rsp.size() == 0) begin
        $error("result word with nothing pending: read_data %0h speaker_toggle %0b",
               rsp_bus.read_data, rsp_bus.speaker_toggle);
        fails++;
      end else begin
        head_rsp = awaited_rsp.pop_front();
        if (rsp_bus.read_data !== head_rsp.read_data) begin
          $error("read_data expected %0h actual %0h", head_rsp.read_data, rsp_bus.read_data);
          fails++;
        end
        if (rsp_bus.speaker_toggle !== head_rsp.speaker_toggle) begin
          $error("speaker_toggle expected %0b actual %0b",
                 head_rsp.speaker_toggle, rsp_bus.speaker_toggle);
          fails++;
        end
      end
    end
  end

  initial begin
    bmm_pkg::req_t acc;
    bmm_pkg::rsp_t none;
    logic          no_gaps;
    int unsigned   guard;
    start        = 1'b0;
    req_bus      = '0;
    rst_n        = 1'b0;
    none         = '0;
    fails        = 0;
    results_seen = 0;
    n_reads      = 0;
    n_writes     = 0;
    n_card       = 0;
    n_speaker    = 0;
    n_window     = 0;
    no_gaps      = 1'b0;
    lc_read_ram  = 1'b0;
    lc_write_en  = 1'b0;
    lc_bank1     = 1'b0;
    foreach (shadow_main[i]) shadow_main[i] = '0;
    foreach (shadow_bank1[i]) shadow_bank1[i] = '0;
    foreach (shadow_bank2[i]) shadow_bank2[i] = '0;

    plan.push_back(row(bmm_pkg::OpRead,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hFFFF, 8'hFF, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'h0000, 8'hFF, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'h0000, 8'h00, 1'b1, 8'hFF, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hFFFF, 8'hA5, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hFFFF, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC030, 8'h00, 1'b1, 8'h00, 1'b1));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hC030, 8'hFF, 1'b1, 8'h00, 1'b1));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC000, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hC0FF, 8'h5A, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC0E0, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hC0E1, 8'hFF, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC0EC, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC08B, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hD000, 8'h11, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hD000, 8'h00, 1'b0, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hC083, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hDFFF, 8'h22, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hDFFF, 8'h00, 1'b0, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC089, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hD000, 8'h00, 1'b0, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hFFFF, 8'hC3, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC08E, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpWrite, 16'hD000, 8'h44, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hC084, 8'h00, 1'b1, 8'h00, 1'b0));
    plan.push_back(row(bmm_pkg::OpRead,  16'hDFFF, 8'h00, 1'b0, 8'h00, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      issue(plan[i].acc, plan[i].typed, plan[i].want);
      pause_bus(gap_length());
    end

    for (int unsigned k = 0; k < RandomWords; k++) begin
      if (k % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      acc.opcode      = 1'($urandom);
      acc.bus_address = pick_address();
      acc.write_data  = 8'($urandom);
      issue(acc, 1'b0, none);
      if (!no_gaps) pause_bus(gap_length());
    end

    start <= 1'b0;
    guard = 0;
    while (awaited_rsp.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_rsp.size() != 0) begin
      $error("%0d result words never arrived", awaited_rsp.size());
      fails++;
    end
    repeat (4) @(posedge clk);

    $display("covered %0d results: %0d reads, %0d writes, %0d card switches, %0d speaker hits",
             results_seen, n_reads, n_writes, n_card, n_speaker);
    $display("bank window accesses that reached a bank store: %0d", n_window);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
